[hdl/pus_pkg.sv]
package pus_pkg;

  localparam int unsigned HEADER_BYTES = 20;
  localparam int unsigned LEN_FIRST    = 16;
  localparam int unsigned PROC_MIN_LEN = 12;

  localparam logic [15:0] PROC_CODE      = 16'h0376;
  localparam logic [7:0]  FLAG_COMPILED  = 8'h10;
  localparam logic [7:0]  FLAG_ENCRYPTED = 8'h20;
  localparam logic [7:0]  FLAG_LOCKED    = 8'h40;
  localparam logic [32:0] PROC_EXTRA     = 33'd14;

  localparam logic [8:0] POS_TOKEN_HI = 9'd2;
  localparam logic [8:0] POS_TOKEN_LO = 9'd3;
  localparam logic [8:0] POS_BODY     = 9'd4;
  localparam logic [8:0] POS_SIZE_END = 9'd7;
  localparam logic [8:0] POS_ACCEL_HI = 9'd8;
  localparam logic [8:0] POS_ACCEL_LO = 9'd9;
  localparam logic [8:0] POS_FLAGS    = 9'd10;
  localparam logic [8:0] POS_SEED     = 9'd11;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_LINE_ERR     = 2'd1;
  localparam logic [1:0] ST_BAD_PROC_LEN = 2'd2;
  localparam logic [1:0] ST_ZERO_IN_PROC = 2'd3;

  typedef struct packed {
    logic        restart;
    logic        clear_phase;
    logic        start_proc;
    logic        load_accel;
    logic        load_main;
    logic        advance;
    logic [7:0]  data;
    logic [31:0] proc_size;
  } key_ctl_t;

endpackage

[hdl/pus_in_if.sv]
interface pus_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_in;
  logic       first_byte;

  modport source (output valid, output data_in, output first_byte, input ready);
  modport sink (input valid, input data_in, input first_byte, output ready);
endinterface

[hdl/pus_out_if.sv]
interface pus_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_out;
  logic [1:0]  status;
  logic        decrypting;
  logic [15:0] unlock_count;

  modport source (output valid, output data_out, output status, output decrypting,
                  output unlock_count, input ready);
  modport sink (input valid, input data_out, input status, input decrypting,
                input unlock_count, output ready);
endinterface

[hdl/pus_keygen.sv]
module pus_keygen
  import pus_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  key_ctl_t   ctl,
  output logic [7:0] key_byte
);

  logic [31:0] key_main, key_main_next;
  logic [31:0] key_step, key_step_next;
  logic [15:0] key_accel, key_accel_next;
  logic        pair_phase, pair_phase_next;
  logic [31:0] sum;

  assign key_byte = pair_phase ? key_main[7:0] : key_main[15:8];
  assign sum      = key_main + key_step;

  always_comb begin
    key_main_next   = key_main;
    key_step_next   = key_step;
    key_accel_next  = key_accel;
    pair_phase_next = pair_phase;
    if (ctl.restart) begin
      key_main_next   = '0;
      key_step_next   = 32'd1;
      key_accel_next  = '0;
      pair_phase_next = 1'b0;
    end else begin
      if (ctl.advance) begin
        if (!pair_phase) begin
          pair_phase_next = 1'b1;
        end else begin
          key_main_next   = {sum[0], sum[31:1]};
          key_step_next   = key_step + {16'd0, key_accel};
          pair_phase_next = 1'b0;
        end
      end
      if (ctl.load_accel) begin
        key_accel_next = {key_accel[7:0], ctl.data};
      end
      if (ctl.load_main) begin
        key_main_next = {ctl.proc_size[23:0], ctl.data};
      end
      if (ctl.start_proc) begin
        key_step_next   = 32'd1;
        pair_phase_next = 1'b0;
      end
      if (ctl.clear_phase) begin
        pair_phase_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_main   <= '0;
      key_step   <= 32'd1;
      key_accel  <= '0;
      pair_phase <= 1'b0;
    end else if (en) begin
      key_main   <= key_main_next;
      key_step   <= key_step_next;
      key_accel  <= key_accel_next;
      pair_phase <= pair_phase_next;
    end
  end

endmodule

[hdl/procedure_unlock_stream.sv]
// Streams a tokenized program listing one byte per transfer and returns one byte per
// transfer: the 20-byte file header passes through, then each line is parsed by its
// leading word-length byte, procedure lines lose their locked flag, and an encrypted
// procedure that fits in the listing and is not compiled has its flag cleared and the
// lines in its range XOR-decrypted after their four-byte line headers. Every byte is
// handled combinationally between the input handshake and the result register, so one
// byte is taken each clock while the result side keeps up; the result register parts
// the two sides and a stalled result holds the input off. Assert first_byte on byte 0
// of each file to restart parsing. After a line length error or a zero line in a decrypted
// range the rest of the file passes through unchanged until the next first_byte.
module procedure_unlock_stream
  import pus_pkg::*;
(
  input logic       clk,
  input logic       rst,
  pus_in_if.sink    item,
  pus_out_if.source result
);

  logic [4:0]  header_count, header_count_next;
  logic [31:0] listing_remaining, listing_remaining_next;
  logic [8:0]  line_position, line_position_next;
  logic [8:0]  line_bytes, line_bytes_next;
  logic [15:0] token_word, token_word_next;
  logic [31:0] proc_size, proc_size_next;
  logic [31:0] proc_offset, proc_offset_next;
  logic        decrypt_active, decrypt_active_next;
  logic        line_encrypted, line_encrypted_next;
  logic        halted, halted_next;
  logic [15:0] found_count, found_count_next;

  logic        fire;
  logic [7:0]  d;
  logic [7:0]  ob;
  logic [1:0]  st;
  logic        dec;
  logic [8:0]  x;
  logic [9:0]  pos_inc;
  logic        in_range;
  logic        is_proc;
  logic        bump_enc, bump_lock;
  logic [15:0] count_mid;
  logic [32:0] proc_limit;
  logic [32:0] left;
  logic [7:0]  key_byte;
  key_ctl_t    kctl;

  assign item.ready = !result.valid || result.ready;
  assign fire       = item.valid && item.ready;
  assign d          = item.data_in;
  assign x          = {d, 1'b0};
  assign proc_limit = {1'b0, proc_size} + PROC_EXTRA;
  assign left       = {1'b0, listing_remaining} + {24'd0, line_bytes};
  assign pos_inc    = {1'b0, line_position} + 10'd1;

  pus_keygen u_keygen (
    .clk      (clk),
    .rst      (rst),
    .en       (fire),
    .ctl      (kctl),
    .key_byte (key_byte)
  );

  always_comb begin
    header_count_next      = header_count;
    listing_remaining_next = listing_remaining;
    line_position_next     = line_position;
    line_bytes_next        = line_bytes;
    token_word_next        = token_word;
    proc_size_next         = proc_size;
    proc_offset_next       = proc_offset;
    decrypt_active_next    = decrypt_active;
    line_encrypted_next    = line_encrypted;
    halted_next            = halted;
    ob                     = d;
    st                     = ST_OK;
    dec                    = 1'b0;
    in_range               = 1'b0;
    is_proc                = 1'b0;
    bump_enc               = 1'b0;
    bump_lock              = 1'b0;
    kctl                   = '0;
    kctl.data              = d;
    kctl.proc_size         = proc_size;

    if (item.first_byte) begin
      header_count_next      = 5'd1;
      listing_remaining_next = '0;
      line_position_next     = '0;
      line_bytes_next        = '0;
      token_word_next        = '0;
      proc_size_next         = '0;
      proc_offset_next       = '0;
      decrypt_active_next    = 1'b0;
      line_encrypted_next    = 1'b0;
      halted_next            = 1'b0;
      kctl.restart           = 1'b1;
    end else if (header_count < 5'(HEADER_BYTES)) begin
      if (header_count >= 5'(LEN_FIRST)) begin
        listing_remaining_next = {listing_remaining[23:0], d};
      end
      header_count_next = header_count + 5'd1;
    end else if (!halted) begin
      if (line_position == '0) begin
        if (listing_remaining == '0) begin
          decrypt_active_next = 1'b0;
          line_encrypted_next = 1'b0;
        end else begin
          in_range = decrypt_active && ({1'b0, proc_offset} < proc_limit);
          if (!in_range) begin
            decrypt_active_next = 1'b0;
          end
          if (x == '0) begin
            st                  = in_range ? ST_ZERO_IN_PROC : ST_LINE_ERR;
            halted_next         = 1'b1;
            decrypt_active_next = 1'b0;
            line_encrypted_next = 1'b0;
          end else if ({23'd0, x} > listing_remaining) begin
            st                  = ST_LINE_ERR;
            halted_next         = 1'b1;
            decrypt_active_next = 1'b0;
            line_encrypted_next = 1'b0;
          end else begin
            listing_remaining_next = listing_remaining - {23'd0, x};
            line_bytes_next        = x;
            line_position_next     = 9'd1;
            line_encrypted_next    = in_range;
            kctl.clear_phase       = 1'b1;
            if (in_range) begin
              proc_offset_next = proc_offset + {23'd0, x};
            end
          end
        end
      end else begin
        if (line_encrypted && line_position >= POS_BODY) begin
          dec          = 1'b1;
          ob           = d ^ key_byte;
          kctl.advance = 1'b1;
        end
        if (line_position == POS_TOKEN_HI || line_position == POS_TOKEN_LO) begin
          token_word_next = {token_word[7:0], d};
        end
        is_proc = line_bytes >= 9'(PROC_MIN_LEN) && token_word_next == PROC_CODE;
        if (is_proc && !line_encrypted) begin
          if (line_position inside {[POS_BODY:POS_SIZE_END]}) begin
            proc_size_next = {proc_size[23:0], d};
          end else if (line_position inside {POS_ACCEL_HI, POS_ACCEL_LO}) begin
            kctl.load_accel = 1'b1;
          end else if (line_position == POS_SEED) begin
            kctl.load_main = 1'b1;
          end
        end
        if (is_proc && line_position == POS_FLAGS) begin
          if (!line_encrypted && (ob & FLAG_ENCRYPTED) != '0) begin
            if (proc_limit < left) begin
              bump_enc = 1'b1;
              if ((ob & FLAG_COMPILED) == '0) begin
                ob                  = ob & ~FLAG_ENCRYPTED;
                decrypt_active_next = 1'b1;
                proc_offset_next    = {23'd0, line_bytes};
                kctl.start_proc     = 1'b1;
              end
            end else begin
              st = ST_BAD_PROC_LEN;
            end
          end
          if ((ob & FLAG_LOCKED) != '0) begin
            ob        = ob & ~FLAG_LOCKED;
            bump_lock = 1'b1;
          end
        end
        if (pos_inc >= {1'b0, line_bytes}) begin
          line_position_next = '0;
        end else begin
          line_position_next = pos_inc[8:0];
        end
      end
    end

    if (item.first_byte) begin
      count_mid        = '0;
      found_count_next = '0;
    end else begin
      count_mid = (bump_enc && found_count != 16'hFFFF) ? found_count + 16'd1
                                                         : found_count;
      found_count_next = (bump_lock && count_mid != 16'hFFFF) ? count_mid + 16'd1
                                                              : count_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count      <= '0;
      listing_remaining <= '0;
      line_position     <= '0;
      line_bytes        <= '0;
      token_word        <= '0;
      proc_size         <= '0;
      proc_offset       <= '0;
      decrypt_active    <= 1'b0;
      line_encrypted    <= 1'b0;
      halted            <= 1'b0;
      found_count       <= '0;
    end else if (fire) begin
      header_count      <= header_count_next;
      listing_remaining <= listing_remaining_next;
      line_position     <= line_position_next;
      line_bytes        <= line_bytes_next;
      token_word        <= token_word_next;
      proc_size         <= proc_size_next;
      proc_offset       <= proc_offset_next;
      decrypt_active    <= decrypt_active_next;
      line_encrypted    <= line_encrypted_next;
      halted            <= halted_next;
      found_count       <= found_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (fire) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.data_out     <= ob;
      result.status       <= st;
      result.decrypting   <= dec;
      result.unlock_count <= found_count_next;
    end
  end

endmodule

[hdl/pus_chk.sv]
module pus_chk
  import pus_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        first_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  data_out,
  input logic [1:0]  status,
  input logic        decrypting,
  input logic [15:0] count
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_out) && $stable(count))
    else $error("result changed while stalled");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input held off with empty result register");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && first_byte |=>
      out_valid && count == '0 && status == ST_OK && !decrypting)
    else $error("restart byte did not give a clean result");

  a_dec_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && decrypting |-> status == ST_OK)
    else $error("decrypted byte carries an error");

endmodule

bind procedure_unlock_stream pus_chk u_pus_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (item.valid),
  .in_ready   (item.ready),
  .first_byte (item.first_byte),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .data_out   (result.data_out),
  .status     (result.status),
  .decrypting (result.decrypting),
  .count      (result.unlock_count)
);
